// ----- sv/sha256_block_hash_core_macros.svh -----
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef SHA256_BLOCK_HASH_CORE_MACROS_SVH
`define SHA256_BLOCK_HASH_CORE_MACROS_SVH

// same-cycle implication
`define S256BH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define S256BH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/s256bh_pkg.sv -----
`default_nettype none

package s256bh_pkg;

    localparam int WORD_W     = 32;
    localparam int HASH_WORDS = 8;
    localparam int WIN_WORDS  = 16;
    localparam int ROUNDS     = 64;
    localparam int CNT_W      = $clog2(WIN_WORDS);
    localparam int RND_W      = $clog2(ROUNDS);
    localparam int IDX_W      = $clog2(HASH_WORDS);

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [0:HASH_WORDS-1][WORD_W-1:0] hash_t;
    typedef logic [0:WIN_WORDS-1][WORD_W-1:0] win_t;

    typedef struct packed {
        logic             shift_in;
        logic             load;
        logic             step;
        logic [RND_W-1:0] rnd;
    } ctl_t;

    localparam hash_t INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t v, input int s);
        rotr = (v >> s) | (v << (WORD_W - s));
    endfunction

    function automatic word_t sig0(input word_t x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t sig1(input word_t x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t big0(input word_t x);
        big0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big1(input word_t x);
        big1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t ch(input word_t x, input word_t y, input word_t z);
        ch = (x & y) ^ (~x & z);
    endfunction

    function automatic word_t maj(input word_t x, input word_t y, input word_t z);
        maj = (x & y) ^ (x & z) ^ (y & z);
    endfunction

endpackage

`default_nettype wire

// ----- sv/s256bh_compress.sv -----
`default_nettype none

module s256bh_compress
    import s256bh_pkg::*;
(
    input  wire logic  clk,
    input  wire word_t word,
    input  wire ctl_t  ctl,
    input  wire hash_t chain,
    output hash_t      vars
);

    win_t  win_reg;
    hash_t vars_reg;
    hash_t vars_next;
    word_t w_new;
    word_t t1;
    word_t t2;

    // rolling schedule window, oldest word at index 0
    assign w_new = win_reg[0] + sig0(win_reg[1]) + win_reg[9] + sig1(win_reg[14]);

    always_comb
    begin
        t1 = vars_reg[7] + big1(vars_reg[4]) + ch(vars_reg[4], vars_reg[5], vars_reg[6])
             + ROUND_K[ctl.rnd] + win_reg[0];
        t2 = big0(vars_reg[0]) + maj(vars_reg[0], vars_reg[1], vars_reg[2]);
        vars_next    = {vars_reg[0:6], vars_reg[7]};
        vars_next[1] = vars_reg[0];
        vars_next[2] = vars_reg[1];
        vars_next[3] = vars_reg[2];
        vars_next[4] = vars_reg[3] + t1;
        vars_next[5] = vars_reg[4];
        vars_next[6] = vars_reg[5];
        vars_next[7] = vars_reg[6];
        vars_next[0] = t1 + t2;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift_in)
        begin
            win_reg <= {win_reg[1:WIN_WORDS-1], word};
        end
        else if (ctl.step)
        begin
            win_reg <= {win_reg[1:WIN_WORDS-1], w_new};
        end
        if (ctl.load)
        begin
            vars_reg <= chain;
        end
        else if (ctl.step)
        begin
            vars_reg <= vars_next;
        end
    end

    assign vars = vars_reg;

endmodule

`default_nettype wire

// ----- sv/sha256_block_hash_core.sv -----
// SHA-256 over an already padded message. Words enter on s_axis, 32 bits each,
// most significant byte first, sixteen to a 512-bit block; msg_start on a word
// reloads the initial hash and begins a new block there, dropping any partial
// block; msg_end is looked at only on the sixteenth word. A word that does not
// end a block leaves the core idle and ready for the next word. The sixteenth
// word starts one compression: a single round unit runs the 64 rounds one per
// cycle while the schedule rolls through a 16-word shift window, then the fold
// state adds the result into the chaining hash. When the block carried
// msg_end, the eight digest words follow on m_axis, index 0 first, tlast on
// index 7. No request is taken after the sixteenth word of a block until the
// fold is done and, after a final block, until the last digest word has left.
`default_nettype none

`include "sha256_block_hash_core_macros.svh"

module sha256_block_hash_core
    import s256bh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // word[31:0]
    input  wire logic [1:0]  s_axis_tuser,  // msg_end, msg_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // digest_word[31:0]
    output logic [2:0]       m_axis_tuser,  // word_index[2:0]
    output logic             m_axis_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_FOLD  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIN_WORDS - 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HASH_WORDS - 1);

    state_t           state_reg, state_next;
    hash_t            chain_reg, chain_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] cnt_eff;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             fin_reg, fin_next;
    logic             in_acc;
    ctl_t             ctl;
    hash_t            vars;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign cnt_eff = s_axis_tuser[0] ? '0 : cnt_reg;

    always_comb
    begin
        state_next    = state_reg;
        chain_next    = chain_reg;
        cnt_next      = cnt_reg;
        rnd_next      = rnd_reg;
        idx_next      = idx_reg;
        fin_next      = fin_reg;
        ctl           = '0;
        ctl.rnd       = rnd_reg;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    ctl.shift_in = 1'b1;
                    if (s_axis_tuser[0])
                    begin
                        chain_next = INIT_HASH;
                    end
                    cnt_next = cnt_eff + 1'b1;
                    if (cnt_eff == CNT_LAST)
                    begin
                        ctl.load   = 1'b1;
                        fin_next   = s_axis_tuser[1];
                        rnd_next   = '0;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_ROUND:
            begin
                ctl.step = 1'b1;
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == RND_LAST)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    chain_next[i] = chain_reg[i] + vars[i];
                end
                idx_next   = '0;
                state_next = fin_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chain_reg <= INIT_HASH;
            cnt_reg   <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chain_reg <= chain_next;
            cnt_reg   <= cnt_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            fin_reg   <= fin_next;
        end
    end

    s256bh_compress u_compress (
        .clk   (clk),
        .word  (s_axis_tdata),
        .ctl   (ctl),
        .chain (chain_reg),
        .vars  (vars)
    );

    assign m_axis_tdata = chain_reg[idx_reg];
    assign m_axis_tuser = idx_reg;
    assign m_axis_tlast = (idx_reg == IDX_LAST);

    `S256BH_ASSERT_NOW(a_ready_no_out, s_axis_tready, !m_axis_tvalid, "input open during output")
    `S256BH_ASSERT_NEXT(a_block_starts,
        in_acc && !s_axis_tuser[0] && (cnt_reg == CNT_LAST),
        (state_reg == ST_ROUND) && (rnd_reg == '0), "full block did not start rounds")
    `S256BH_ASSERT_NEXT(a_rounds_end, (state_reg == ST_ROUND) && (rnd_reg == RND_LAST),
        state_reg == ST_FOLD, "rounds did not end in fold")
    `S256BH_ASSERT_NEXT(a_fold_no_digest, (state_reg == ST_FOLD) && !fin_reg,
        s_axis_tready && !m_axis_tvalid, "digest on non-final block")
    `S256BH_ASSERT_NEXT(a_last_frees, m_axis_tvalid && m_axis_tready && m_axis_tlast,
        s_axis_tready, "input not reopened after last digest word")

endmodule

`default_nettype wire
